/* design/modexp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_pkg: shared types and constants
// Operand width, derived counter width and sequencer states for the
// modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

	localparam int OPERAND_BITS = 40;
	localparam int CNT_W        = $clog2(OPERAND_BITS);
	localparam int WIDE_W       = OPERAND_BITS + 2;

	typedef logic [OPERAND_BITS-1:0] operand_t;
	typedef logic [CNT_W-1:0]        bit_cnt_t;
	typedef logic [WIDE_W-1:0]       wide_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CHECK,
		ST_MUL_P,
		ST_MUL_B,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

/* design/modexp_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_req_if: request channel
// Valid/ready channel carrying base, exponent and modulus.
// ----------------------------------------------------------------------------
interface modexp_req_if;
	import modexp_pkg::*;

	logic     valid;
	logic     ready;
	operand_t base_value;
	operand_t power;
	operand_t modulus;

	modport source (output valid, output base_value, output power, output modulus,
		input ready);
	modport sink (input valid, input base_value, input power, input modulus,
		output ready);

endinterface
`default_nettype wire

/* design/modexp_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_rsp_if: response channel
// Valid/ready channel carrying the residue.
// ----------------------------------------------------------------------------
interface modexp_rsp_if;
	import modexp_pkg::*;

	logic     valid;
	logic     ready;
	operand_t residue;

	modport source (output valid, output residue, input ready);
	modport sink (input valid, input residue, output ready);

endinterface
`default_nettype wire

/* design/modular_exponentiation.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation: base ^ power mod modulus
// Right-to-left square and multiply; every modular product is formed
// bit-serially by one shared double-add-reduce unit, one operand bit a cycle.
// ----------------------------------------------------------------------------
// latency from accept to result valid grows with the bit length of power and
// with its number of set bits, as the shared double-add-reduce unit forms
// every product one operand bit at a time
// throughput: one word at a time, the next request is taken once the result
// has moved into the output register
// reset clears the sequencer and the output valid; nothing is kept between words
module modular_exponentiation (
	input  wire          clk,
	input  wire          arst_n,
	modexp_req_if.sink   req,
	modexp_rsp_if.source rsp
);
	import modexp_pkg::*;

	state_t   state_q, state_d;
	operand_t acc_q;
	operand_t x_q;
	operand_t y_q;
	operand_t base_q;
	operand_t prod_q;
	operand_t expo_q;
	operand_t mod_q;
	bit_cnt_t cnt_q;
	operand_t residue_q;
	logic     rsp_valid_q;

	logic     last_bit;
	logic     rsp_load;
	logic     req_ready;
	operand_t addend;
	wide_t    sum_w, mod_w, mod2_w, diff1_w, diff2_w;
	operand_t unit_res;

	localparam bit_cnt_t CNT_TOP = bit_cnt_t'(OPERAND_BITS - 1);
	localparam operand_t ONE     = operand_t'(1);

	assign last_bit = (cnt_q == '0);

	// shared unit: (2*acc + addend) mod m, addend taken when the top bit of y is set
	always_comb begin
		addend  = y_q[OPERAND_BITS-1] ? x_q : '0;
		sum_w   = {1'b0, acc_q, 1'b0} + {2'b00, addend};
		mod_w   = {2'b00, mod_q};
		mod2_w  = {1'b0, mod_q, 1'b0};
		diff1_w = sum_w - mod_w;
		diff2_w = sum_w - mod2_w;
		if (mod_q == '0) begin
			// no reduction: wraps at the operand width
			unit_res = sum_w[OPERAND_BITS-1:0];
		end else if (sum_w >= mod2_w) begin
			unit_res = diff2_w[OPERAND_BITS-1:0];
		end else if (sum_w >= mod_w) begin
			unit_res = diff1_w[OPERAND_BITS-1:0];
		end else begin
			unit_res = sum_w[OPERAND_BITS-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_REDUCE;
			end
			ST_REDUCE: begin
				if (last_bit) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (expo_q == '0) state_d = ST_DONE;
				else if (expo_q[0]) state_d = ST_MUL_P;
				else state_d = ST_MUL_B;
			end
			ST_MUL_P: begin
				if (last_bit) state_d = ST_MUL_B;
			end
			ST_MUL_B: begin
				if (last_bit) state_d = ST_CHECK;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req_ready = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			ST_IDLE: req_ready = 1'b1;
			ST_DONE: rsp_load = !rsp_valid_q || rsp.ready;
			default: begin
				req_ready = 1'b0;
				rsp_load  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					// reduce the base first: shift its bits in with an addend of one
					y_q    <= req.base_value;
					x_q    <= ONE;
					acc_q  <= '0;
					cnt_q  <= CNT_TOP;
					expo_q <= req.power;
					mod_q  <= req.modulus;
				end
			end
			ST_REDUCE: begin
				acc_q <= unit_res;
				y_q   <= y_q << 1;
				cnt_q <= cnt_q - 1'b1;
				if (last_bit) begin
					base_q <= unit_res;
					prod_q <= ONE;
				end
			end
			ST_CHECK: begin
				acc_q <= '0;
				cnt_q <= CNT_TOP;
				y_q   <= base_q;
				x_q   <= expo_q[0] ? prod_q : base_q;
			end
			ST_MUL_P: begin
				if (last_bit) begin
					prod_q <= unit_res;
					// set up the squaring of the base
					acc_q  <= '0;
					cnt_q  <= CNT_TOP;
					x_q    <= base_q;
					y_q    <= base_q;
				end else begin
					acc_q <= unit_res;
					y_q   <= y_q << 1;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			ST_MUL_B: begin
				acc_q <= unit_res;
				y_q   <= y_q << 1;
				cnt_q <= cnt_q - 1'b1;
				if (last_bit) begin
					base_q <= unit_res;
					expo_q <= expo_q >> 1;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			residue_q <= prod_q;
		end
	end

	assign req.ready   = req_ready;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.residue = residue_q;

endmodule
`default_nettype wire
